// ===== sv/fabs_pkg.sv =====
// Shared types, constants and register codes for the fill-and-brew sequencer.
`default_nettype none

package fabs_pkg;

  // Fixed process limits
  localparam logic [11:0] ONE_LITRE_LEVEL  = 12'd680;
  localparam logic [31:0] FILL1_TIMEOUT_MS = 32'd30000;
  localparam logic [16:0] FILL2_DEFAULT_MS = 17'd30000;
  localparam logic [1:0]  CONFIRM_TICKS    = 2'd3;
  localparam logic [15:0] MS_PER_MINUTE    = 16'd60000;
  localparam int unsigned BREW_LIMIT_W     = 22;
  localparam int unsigned CFG_INDEX_W      = 3;
  localparam int unsigned CFG_DATA_W       = 17;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_INIT   = 3'd1,
    PH_FILL1  = 3'd2,
    PH_FILL2  = 3'd3,
    PH_BREW   = 3'd4,
    PH_DECIDE = 3'd5,
    PH_DONE   = 3'd6,
    PH_ERROR  = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    FAULT_NONE      = 2'd0,
    FAULT_FILL1_TO  = 2'd1,
    FAULT_FILL2_TO  = 2'd2,
    FAULT_LOW_LEVEL = 2'd3
  } fault_t;

  typedef enum logic [2:0] {
    CFG_TARGET_LEVEL  = 3'd0,
    CFG_PROTECT_LEVEL = 3'd1,
    CFG_STAGE_TWO_TO  = 3'd2,
    CFG_BREW_MINUTES  = 3'd3,
    CFG_MANUAL_DRAIN  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [11:0] level_sample;
    logic        run_request;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic   inlet_open;
    logic   pump_on;
    logic   sampling_on;
    logic   clear_run;
    logic   drain_request;
    phase_t phase;
    fault_t fault_cause;
  } out_item_t;

  // Settings as the sequencer consumes them (limits already scaled)
  typedef struct packed {
    logic [11:0]             target_level;
    logic [11:0]             protect_level;
    logic [16:0]             fill2_limit_ms;
    logic [BREW_LIMIT_W-1:0] brew_limit_ms;
    logic                    manual_drain;
  } cfg_t;

endpackage

`default_nettype wire

// ===== sv/fabs_cfg.sv =====
// Configuration register file; scales brew time and substitutes the default fill-2 timeout.
`default_nettype none

module fabs_cfg
  import fabs_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   wr_en,
  input  wire logic [CFG_INDEX_W-1:0] wr_index,
  input  wire logic [CFG_DATA_W-1:0]  wr_data,
  output cfg_t                        cfg
);

  cfg_t cfg_q;

  // Write one register per transaction; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.target_level   <= '0;
      cfg_q.protect_level  <= '0;
      cfg_q.fill2_limit_ms <= FILL2_DEFAULT_MS;
      cfg_q.brew_limit_ms  <= '0;
      cfg_q.manual_drain   <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        CFG_TARGET_LEVEL:  cfg_q.target_level  <= wr_data[11:0];
        CFG_PROTECT_LEVEL: cfg_q.protect_level <= wr_data[11:0];
        CFG_STAGE_TWO_TO: begin
          // Zero timeout falls back to the default
          cfg_q.fill2_limit_ms <= (wr_data == '0) ? FILL2_DEFAULT_MS : wr_data;
        end
        CFG_BREW_MINUTES: begin
          cfg_q.brew_limit_ms <= BREW_LIMIT_W'(wr_data[5:0]) *
                                 BREW_LIMIT_W'(MS_PER_MINUTE);
        end
        CFG_MANUAL_DRAIN:  cfg_q.manual_drain  <= wr_data[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== sv/fill_and_brew_sequencer.sv =====
// Top level of the fill-and-brew sequencer: phase machine and result register.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_ready   | in_data   (in_item_t)
//   out     | output    | out_valid / out_ready | out_data  (out_item_t)
//   cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One tick item is taken per cycle unless stalled; its result appears in the result
// register in the cycle after acceptance. The phase update is one 32-bit subtract and
// compare deep. Input is taken whenever the result register is empty or being
// drained, so a stalled consumer holds off the producer only while a result waits.
// Synchronous reset returns to idle with all drives off; cfg_ready is always high.
`default_nettype none

module fill_and_brew_sequencer
  import fabs_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output      logic                   in_ready,
  input  wire in_item_t               in_data,
  output      logic                   out_valid,
  input  wire logic                   out_ready,
  output out_item_t                   out_data,
  input  wire logic                   cfg_valid,
  output      logic                   cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t cfg;

  fabs_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign cfg_ready = 1'b1;

  // Sequencer state
  phase_t      phase, phase_next;
  logic [31:0] phase_start, phase_start_next;
  logic [31:0] brew_start, brew_start_next;
  logic [1:0]  confirm_count, confirm_count_next;
  logic        inlet, inlet_next;
  logic        pump, pump_next;
  logic        sampling, sampling_next;
  fault_t      fault, fault_next;
  logic        clear_run, drain_request;

  logic        in_fire;
  logic [31:0] phase_elapsed, brew_elapsed;
  logic [1:0]  count_inc;
  logic        below_litre, at_target, below_protect, count_full;

  assign in_ready = ~out_valid | out_ready;
  assign in_fire  = in_valid & in_ready;

  assign phase_elapsed = in_data.now_ms - phase_start;
  assign brew_elapsed  = in_data.now_ms - brew_start;
  assign count_inc     = confirm_count + 2'd1;
  assign count_full    = (count_inc >= CONFIRM_TICKS);
  assign below_litre   = (in_data.level_sample < ONE_LITRE_LEVEL);
  assign at_target     = (in_data.level_sample >= cfg.target_level);
  assign below_protect = (in_data.level_sample < cfg.protect_level);

  // Next state and result for the tick at the input
  always_comb begin
    phase_next         = phase;
    phase_start_next   = phase_start;
    brew_start_next    = brew_start;
    confirm_count_next = confirm_count;
    inlet_next         = inlet;
    pump_next          = pump;
    sampling_next      = sampling;
    fault_next         = fault;
    clear_run          = 1'b0;
    drain_request      = 1'b0;

    if (!in_data.run_request) begin
      // Run dropped: close everything and return to idle
      if (phase != PH_IDLE) begin
        sampling_next      = 1'b0;
        inlet_next         = 1'b0;
        pump_next          = 1'b0;
        confirm_count_next = '0;
        phase_next         = PH_IDLE;
        phase_start_next   = '0;
        brew_start_next    = '0;
        fault_next         = FAULT_NONE;
      end
    end else begin
      case (phase)
        PH_IDLE: phase_next = PH_INIT;
        PH_INIT: begin
          inlet_next         = 1'b0;
          pump_next          = 1'b0;
          sampling_next      = 1'b1;
          phase_start_next   = in_data.now_ms;
          confirm_count_next = '0;
          phase_next         = PH_FILL1;
        end
        PH_FILL1: begin
          if (below_litre && (phase_elapsed >= FILL1_TIMEOUT_MS)) begin
            inlet_next = 1'b0;
            clear_run  = 1'b1;
            fault_next = FAULT_FILL1_TO;
            phase_next = PH_ERROR;
          end else if (below_litre) begin
            confirm_count_next = '0;
            inlet_next         = 1'b1;
          end else if (count_full) begin
            phase_start_next   = in_data.now_ms;
            confirm_count_next = '0;
            phase_next         = PH_FILL2;
          end else begin
            confirm_count_next = count_inc;
            inlet_next         = 1'b1;
          end
        end
        PH_FILL2: begin
          if (phase_elapsed >= 32'(cfg.fill2_limit_ms)) begin
            inlet_next = 1'b0;
            clear_run  = 1'b1;
            fault_next = FAULT_FILL2_TO;
            phase_next = PH_ERROR;
          end else if (!at_target) begin
            confirm_count_next = '0;
            inlet_next         = 1'b1;
          end else if (count_full) begin
            inlet_next         = 1'b0;
            confirm_count_next = '0;
            brew_start_next    = in_data.now_ms;
            phase_next         = PH_BREW;
          end else begin
            confirm_count_next = count_inc;
            inlet_next         = 1'b1;
          end
        end
        PH_BREW: begin
          // Level check runs before the brew timer
          if (below_protect && count_full) begin
            pump_next          = 1'b0;
            clear_run          = 1'b1;
            confirm_count_next = '0;
            fault_next         = FAULT_LOW_LEVEL;
            phase_next         = PH_ERROR;
          end else begin
            confirm_count_next = below_protect ? count_inc : 2'd0;
            if (brew_elapsed >= 32'(cfg.brew_limit_ms)) begin
              pump_next  = 1'b0;
              phase_next = PH_DECIDE;
            end else begin
              pump_next = 1'b1;
            end
          end
        end
        PH_DECIDE: begin
          drain_request = ~cfg.manual_drain;
          clear_run     = 1'b1;
          phase_next    = PH_DONE;
        end
        PH_DONE: begin
          sampling_next = 1'b0;
          clear_run     = 1'b1;
          phase_next    = PH_IDLE;
        end
        PH_ERROR: begin
          inlet_next    = 1'b0;
          pump_next     = 1'b0;
          sampling_next = 1'b0;
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  // Advance state on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      phase_start   <= '0;
      brew_start    <= '0;
      confirm_count <= '0;
      inlet         <= 1'b0;
      pump          <= 1'b0;
      sampling      <= 1'b0;
      fault         <= FAULT_NONE;
    end else if (in_fire) begin
      phase         <= phase_next;
      phase_start   <= phase_start_next;
      brew_start    <= brew_start_next;
      confirm_count <= confirm_count_next;
      inlet         <= inlet_next;
      pump          <= pump_next;
      sampling      <= sampling_next;
      fault         <= fault_next;
    end
  end

  // Hold the result until the consumer takes the transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data.inlet_open    <= inlet_next;
      out_data.pump_on       <= pump_next;
      out_data.sampling_on   <= sampling_next;
      out_data.clear_run     <= clear_run;
      out_data.drain_request <= drain_request;
      out_data.phase         <= phase_next;
      out_data.fault_cause   <= fault_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/fabs_checker.sv =====
// Port-level checks for the fill-and-brew sequencer, bound to the top level.
`default_nettype none

module fabs_checker
  import fabs_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Drain request only on the decide-to-done tick
  a_drain_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.drain_request |-> out_data.phase == PH_DONE)
    else $error("drain request outside done");

  // Idle means all drives off
  a_idle_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.phase == PH_IDLE |->
      !out_data.inlet_open && !out_data.pump_on && !out_data.sampling_on)
    else $error("drive active in idle");

  // Error carries a cause and keeps valve and pump closed
  a_error_safe: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.phase == PH_ERROR |->
      out_data.fault_cause != FAULT_NONE && !out_data.inlet_open && !out_data.pump_on)
    else $error("unsafe error result");

  // Dropped run request yields idle with no fault
  a_run_drop: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !in_data.run_request |=>
      out_valid && out_data.phase == PH_IDLE && out_data.fault_cause == FAULT_NONE)
    else $error("run drop did not return to idle");

endmodule

bind fill_and_brew_sequencer fabs_checker u_fabs_checker (.*);

`default_nettype wire
